/* design/bpr_pkg.sv */
// ----------------------------------------------------------------------------
// bpr_pkg: shared types and constants of the bitmap pixel row decoder
// Sizes of the palette, the row and the result queue, command and format
// codes, and the records that travel between the decoder's stages.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH + 1);
  localparam int STRIDE_W    = $clog2(3 * MAX_WIDTH + 4);
  localparam int CFG_W       = 13;
  localparam int OUT_COL_W   = 12;
  localparam int CH_W        = 8;
  localparam int RGB_W       = 3 * CH_W;
  localparam int HELD_W      = 2 * CH_W;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PAL_WRITE = 2'd0,
    CMD_PIXEL     = 2'd1,
    CMD_RESTART   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FMT_PAL4  = 2'd0,
    FMT_PAL8  = 2'd1,
    FMT_BGR24 = 2'd2
  } fmt_e;

  typedef enum logic [0:0] {
    CFG_PIXEL_FORMAT = 1'b0,
    CFG_IMAGE_WIDTH  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_e;

  // One pending pixel: either a palette lookup or a colour known already.
  typedef struct packed {
    logic                 direct;
    logic                 blank;
    logic [PAL_AW-1:0]    idx;
    logic [RGB_W-1:0]     rgb;
    logic [OUT_COL_W-1:0] col;
    logic                 row_end;
    logic                 last;
  } req_t;

  typedef struct packed {
    logic [RGB_W-1:0]     rgb;
    logic [OUT_COL_W-1:0] col;
    logic                 row_end;
    logic                 last;
  } pix_t;

endpackage

/* design/bpr_ram.sv */
// ----------------------------------------------------------------------------
// bpr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and a read
// of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bpr_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bpr_out_fifo.sv */
// ----------------------------------------------------------------------------
// bpr_out_fifo: result queue of the decoder
// A short queue of finished pixels; it lets lookups carry on while the
// output side stalls and reports its fill level for flow control.
// ----------------------------------------------------------------------------
module bpr_out_fifo import bpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pix_t               push_data_i,
  input  logic               pop_i,
  output pix_t               pop_data_o,
  output logic [FIFO_CW-1:0] level_o
);

  pix_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FIFO_AW'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign level_o    = level_q;

endmodule

/* design/bmp_pixel_row_decoder.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_row_decoder: turns stored bitmap row bytes into RGB pixels
// Palette writes fill a 256-entry RAM; data bytes are decoded as 4-bit or
// 8-bit palette pixels or as 24-bit BGR, and row padding is skipped.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                Contents
//  -------  -----------------------  --------------------------------------------
//  in       in_valid_i / in_stall_o  command, palette entry, data byte
//  out      out_valid_o / out_stall_i red, green, blue, column, row_end, run_last
//  cfg      cfg_we_i                 cfg_idx_i selects format or width
//
// An item is taken every cycle while the result queue has room, except after
// a 4-bit byte that yields two pixels, whose second lookup holds the input: the
// palette RAM has one read port. Each pixel passes the slot, RAM and queue.
// Reset clears the row position and the registers; the palette is not
// cleared and must be written before it is read.
// While the output stalls, a four-entry queue absorbs finished pixels.
module bmp_pixel_row_decoder import bpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [CH_W-1:0]      palette_index_i,
  input  logic [CH_W-1:0]      entry_red_i,
  input  logic [CH_W-1:0]      entry_green_i,
  input  logic [CH_W-1:0]      entry_blue_i,
  input  logic [CH_W-1:0]      data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CH_W-1:0]      red_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      blue_o,
  output logic [OUT_COL_W-1:0] column_o,
  output logic                 row_end_o,
  output logic                 run_last_o
);

  // Configuration
  logic [1:0]       fmt_q;
  logic [CFG_W-1:0] image_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q         <= FMT_BGR24;
      image_width_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXEL_FORMAT: fmt_q         <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  image_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Row state
  logic [COL_W-1:0]    col_q, col_d;
  logic [STRIDE_W-1:0] count_q, count_d;
  phase_e              phase_q, phase_d;
  logic [HELD_W-1:0]   held_q, held_d;

  // Lookup slot: up to two pending pixels of the last accepted byte
  logic [1:0] slot_vld_q, slot_vld_d;
  req_t       s0_q, s0_d, s1_q, s1_d;
  req_t       req0, req1;
  logic       req0_vld, req1_vld;

  // Lookup in flight and result queue
  logic               infl_q;
  req_t               infl_meta_q;
  logic [RGB_W-1:0]   ram_rdata;
  logic [FIFO_CW-1:0] fifo_level;
  pix_t               push_pix, pop_pix;
  logic               issue, in_acc, pix_acc, out_acc;

  logic [COL_W-1:0]    eff_w, col1, col2;
  logic [COL_W:0]      w_plus;
  logic [STRIDE_W-1:0] bytes, stride, count_n;
  logic                col_lt, two_pix;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pix_acc = in_acc && (command_i == CMD_PIXEL);

  // A slot entry may go to the RAM only when the queue has room for it
  // alongside the lookup already in flight.
  assign issue = slot_vld_q[0] &&
                 ((32'(fifo_level) + 32'(infl_q)) < FIFO_DEPTH);

  // The input waits until the slot is empty or empties in this cycle.
  assign in_stall_o = slot_vld_q[1] || (slot_vld_q[0] && !issue);

  always_comb begin
    if (image_width_q == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(image_width_q);
    end

    w_plus = {1'b0, eff_w} + (COL_W + 1)'(1);
    unique case (fmt_q)
      FMT_PAL4: bytes = STRIDE_W'(w_plus >> 1);
      FMT_PAL8: bytes = STRIDE_W'(eff_w);
      default:  bytes = STRIDE_W'(eff_w) + STRIDE_W'({eff_w, 1'b0});
    endcase
    stride  = (bytes + STRIDE_W'(3)) & ~STRIDE_W'(3);
    count_n = count_q + STRIDE_W'(1);
  end

  // Decode of one data byte
  always_comb begin
    col1    = col_q + COL_W'(1);
    col2    = col_q + COL_W'(2);
    col_lt  = col_q < eff_w;
    two_pix = 1'b0;

    req0         = '0;
    req0.col     = OUT_COL_W'(col_q);
    req0.row_end = (col1 == eff_w);
    req1         = '0;
    req1.col     = OUT_COL_W'(col1);
    req1.row_end = (col2 == eff_w);
    req1.last    = 1'b1;
    req1.idx     = PAL_AW'(data_byte_i[3:0]);
    req1.blank   = (32'(data_byte_i[3:0]) >= PAL_DEPTH);
    req0_vld     = 1'b0;
    req1_vld     = 1'b0;

    col_d   = col_q;
    count_d = count_q;
    phase_d = phase_q;
    held_d  = held_q;

    unique case (fmt_q)
      FMT_PAL4: begin
        req0.idx   = PAL_AW'(data_byte_i[7:4]);
        req0.blank = (32'(data_byte_i[7:4]) >= PAL_DEPTH);
      end
      FMT_PAL8: begin
        req0.idx   = PAL_AW'(data_byte_i);
        req0.blank = (32'(data_byte_i) >= PAL_DEPTH);
      end
      default: begin
        req0.direct = 1'b1;
        req0.rgb    = {data_byte_i, held_q};
      end
    endcase

    if (pix_acc) begin
      if (col_lt) begin
        unique case (fmt_q)
          FMT_PAL4: begin
            two_pix  = col1 < eff_w;
            req0_vld = 1'b1;
            req1_vld = two_pix;
            col_d    = two_pix ? col2 : col1;
          end
          FMT_PAL8: begin
            req0_vld = 1'b1;
            col_d    = col1;
          end
          default: begin
            unique case (phase_q)
              PH_BLUE: begin
                held_d  = HELD_W'(data_byte_i);
                phase_d = PH_GREEN;
              end
              PH_GREEN: begin
                held_d  = {data_byte_i, held_q[CH_W-1:0]};
                phase_d = PH_RED;
              end
              default: begin
                req0_vld = 1'b1;
                col_d    = col1;
                phase_d  = PH_BLUE;
                held_d   = '0;
              end
            endcase
          end
        endcase
      end
      req0.last = !req1_vld;

      count_d = count_n;
      if (count_n >= stride) begin
        col_d   = '0;
        count_d = '0;
        phase_d = PH_BLUE;
        held_d  = '0;
      end
    end else if (in_acc && (command_i == CMD_RESTART)) begin
      col_d   = '0;
      count_d = '0;
      phase_d = PH_BLUE;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      count_q <= '0;
      phase_q <= PH_BLUE;
      held_q  <= '0;
    end else begin
      col_q   <= col_d;
      count_q <= count_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // Slot: the second entry moves up once the first has gone to the RAM.
  always_comb begin
    slot_vld_d = slot_vld_q;
    s0_d       = s0_q;
    s1_d       = s1_q;
    if (issue) begin
      slot_vld_d = {1'b0, slot_vld_q[1]};
      s0_d       = s1_q;
    end
    if (pix_acc) begin
      slot_vld_d = {req1_vld, req0_vld};
      s0_d       = req0;
      s1_d       = req1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      infl_q     <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      infl_q     <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
    if (issue) begin
      infl_meta_q <= s0_q;
    end
  end

  bpr_ram #(
    .Width (RGB_W),
    .Depth (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_acc && (command_i == CMD_PAL_WRITE) &&
              (32'(palette_index_i) < PAL_DEPTH)),
    .waddr_i (PAL_AW'(palette_index_i)),
    .wdata_i ({entry_red_i, entry_green_i, entry_blue_i}),
    .re_i    (issue),
    .raddr_i (s0_q.idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    push_pix.col     = infl_meta_q.col;
    push_pix.row_end = infl_meta_q.row_end;
    push_pix.last    = infl_meta_q.last;
    if (infl_meta_q.direct) begin
      push_pix.rgb = infl_meta_q.rgb;
    end else if (infl_meta_q.blank) begin
      push_pix.rgb = '0;
    end else begin
      push_pix.rgb = ram_rdata;
    end
  end

  assign out_valid_o = (fifo_level != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  bpr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (infl_q),
    .push_data_i (push_pix),
    .pop_i       (out_acc),
    .pop_data_o  (pop_pix),
    .level_o     (fifo_level)
  );

  assign red_o      = pop_pix.rgb[RGB_W-1:2*CH_W];
  assign green_o    = pop_pix.rgb[2*CH_W-1:CH_W];
  assign blue_o     = pop_pix.rgb[CH_W-1:0];
  assign column_o   = pop_pix.col;
  assign row_end_o  = pop_pix.row_end;
  assign run_last_o = pop_pix.last;

  // The second slot entry is always the low nibble of a 4-bit byte.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_vld_q[1] |-> (slot_vld_q[0] && !s1_q.direct && s1_q.last && !s0_q.last))
    else $error("slot holds a second pixel in the wrong form");

  // A lookup in flight must always find room in the queue.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q |-> (fifo_level < FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // A beat is only taken when the second entry is free.
  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !slot_vld_q[1])
    else $error("beat accepted while the slot was full");

endmodule

/* tb/bmp_pixel_row_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp_pixel_row_decoder_tb: self-checking bench for the bitmap row decoder
// Loads the palette, runs short directed rows in every pixel format, then
// long random row streams under three idling patterns. Each beat accepted is
// decoded by a behavioural copy of the block, and every pixel that leaves the
// block is compared with the oldest pixel predicted.
// ----------------------------------------------------------------------------
module bmp_pixel_row_decoder_tb;
  import bpr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_BEATS   = 560;
  localparam int WIDTH_TOP     = (1 << CFG_W) - 1;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [1:0] FMT_SPARE   = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [OUT_COL_W-1:0] column;
    logic                 row_end;
    logic                 run_last;
  } pixel_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [0:0]           cfg_idx_i       = CFG_PIXEL_FORMAT;
  logic [CFG_W-1:0]     cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i       = CMD_PAL_WRITE;
  logic [CH_W-1:0]      palette_index_i = '0;
  logic [CH_W-1:0]      entry_red_i     = '0;
  logic [CH_W-1:0]      entry_green_i   = '0;
  logic [CH_W-1:0]      entry_blue_i    = '0;
  logic [CH_W-1:0]      data_byte_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [CH_W-1:0]      red_o;
  logic [CH_W-1:0]      green_o;
  logic [CH_W-1:0]      blue_o;
  logic [OUT_COL_W-1:0] column_o;
  logic                 row_end_o;
  logic                 run_last_o;

  bmp_pixel_row_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .palette_index_i (palette_index_i),
    .entry_red_i     (entry_red_i),
    .entry_green_i   (entry_green_i),
    .entry_blue_i    (entry_blue_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .column_o        (column_o),
    .row_end_o       (row_end_o),
    .run_last_o      (run_last_o)
  );

  // Decoder state as the bench sees it.
  logic [RGB_W-1:0]  palette_copy [PAL_DEPTH];
  int unsigned       cur_column;
  int unsigned       cur_row_bytes;
  phase_e            cur_phase;
  logic [HELD_W-1:0] cur_held;
  logic [1:0]        cur_format;
  logic [CFG_W-1:0]  cur_width;
  pixel_t            expected_pixels [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned cycles         = 0;
  int unsigned failures       = 0;
  int unsigned beats_sent     = 0;
  int unsigned pixels_checked = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout: %0d pixels still awaited after %0d cycles",
               expected_pixels.size(), cycles);
      $display("bmp_pixel_row_decoder_tb failed");
      $finish;
    end
  end

  function automatic int unsigned active_width();
    if (cur_width == '0) return 1;
    if (32'(cur_width) > MAX_WIDTH) return MAX_WIDTH;
    return 32'(cur_width);
  endfunction

  // Bytes per stored row, rounded up to a whole word.
  function automatic int unsigned row_stride_bytes(input int unsigned w);
    int unsigned n;
    if (cur_format == FMT_PAL4) n = (w + 1) / 2;
    else if (cur_format == FMT_PAL8) n = w;
    else n = 3 * w;
    return (n + 3) & ~32'd3;
  endfunction

  function automatic pixel_t make_pixel(input logic [RGB_W-1:0] rgb,
                                        input int unsigned col, input int unsigned w);
    pixel_t p;
    p.red      = rgb[23:16];
    p.green    = rgb[15:8];
    p.blue     = rgb[7:0];
    p.column   = col[OUT_COL_W-1:0];
    p.row_end  = (col + 1 == w);
    p.run_last = 1'b0;
    return p;
  endfunction

  task automatic clear_row_position();
    cur_column    = 0;
    cur_row_bytes = 0;
    cur_phase     = PH_BLUE;
    cur_held      = '0;
  endtask

  // Works out the pixels that one accepted beat produces.
  task automatic decode_beat(input logic [1:0] cmd, input logic [7:0] idx,
                             input logic [7:0] r, g, b, data);
    pixel_t      pix [2];
    int          n;
    int unsigned w;
    n = 0;
    w = active_width();
    if (cmd == CMD_PAL_WRITE) begin
      palette_copy[idx] = {r, g, b};
    end else if (cmd == CMD_RESTART) begin
      clear_row_position();
    end else if (cmd == CMD_PIXEL) begin
      if (cur_column < w) begin
        if (cur_format == FMT_PAL4) begin
          pix[n] = make_pixel(palette_copy[{4'h0, data[7:4]}], cur_column, w);
          n++;
          cur_column++;
          // The low nibble is dropped once the row is full.
          if (cur_column < w) begin
            pix[n] = make_pixel(palette_copy[{4'h0, data[3:0]}], cur_column, w);
            n++;
            cur_column++;
          end
        end else if (cur_format == FMT_PAL8) begin
          pix[n] = make_pixel(palette_copy[data], cur_column, w);
          n++;
          cur_column++;
        end else if (cur_phase == PH_BLUE) begin
          cur_held  = {8'h00, data};
          cur_phase = PH_GREEN;
        end else if (cur_phase == PH_GREEN) begin
          cur_held[15:8] = data;
          cur_phase      = PH_RED;
        end else begin
          pix[n] = make_pixel({data, cur_held}, cur_column, w);
          n++;
          cur_column++;
          cur_phase = PH_BLUE;
          cur_held  = '0;
        end
      end
      cur_row_bytes++;
      if (cur_row_bytes >= row_stride_bytes(w)) clear_row_position();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) pix[i].run_last = 1'b1;
      expected_pixels.push_back(pix[i]);
    end
  endtask

  always @(posedge clk_i) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {red_o, green_o, blue_o, column_o, row_end_o, run_last_o};
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: unexpected pixel rgb %02h%02h%02h column %0d at cycle %0d",
                   got.red, got.green, got.blue, got.column, cycles);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display({"ERROR: pixel %0d expected rgb %02h%02h%02h col %0d end %0b last %0b,",
                      " got rgb %02h%02h%02h col %0d end %0b last %0b"},
                     pixels_checked, want.red, want.green, want.blue, want.column,
                     want.row_end, want.run_last, got.red, got.green, got.blue,
                     got.column, got.row_end, got.run_last);
        end
      end
    end
  end

  // Drives one beat and holds it until it is taken.
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] idx,
                           input logic [7:0] r, g, b, data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i       <= cmd;
    palette_index_i <= idx;
    entry_red_i     <= r;
    entry_green_i   <= g;
    entry_blue_i    <= b;
    data_byte_i     <= data;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    decode_beat(cmd, idx, r, g, b, data);
    if (cmd != CMD_IGNORED) beats_sent++;
  endtask

  task automatic send_pixel_byte(input logic [7:0] data);
    send_beat(CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), data);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [RGB_W-1:0] rgb);
    send_beat(CMD_PAL_WRITE, idx, rgb[23:16], rgb[15:8], rgb[7:0],
              8'($urandom_range(255)));
  endtask

  task automatic send_control(input logic [1:0] cmd);
    send_beat(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Holds the input back until every predicted pixel is out and the pipeline
  // has had time to finish beats that produce nothing.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    drain_pixels();
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    if (idx == CFG_PIXEL_FORMAT) cur_format = value[1:0];
    else cur_width = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] fmt, input logic [CFG_W-1:0] width);
    write_reg(CFG_PIXEL_FORMAT, CFG_W'(fmt));
    write_reg(CFG_IMAGE_WIDTH, width);
  endtask

  function automatic logic [7:0] random_data_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly short rows, with the odd very wide or out-of-range width.
  function automatic logic [CFG_W-1:0] random_width();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return CFG_W'($urandom_range(24, 1));
    if (pick < 75) return CFG_W'(1);
    if (pick < 80) return '0;
    if (pick < 90) return CFG_W'($urandom_range(300, 25));
    if (pick < 95) return CFG_W'(MAX_WIDTH);
    return CFG_W'($urandom_range(WIDTH_TOP, MAX_WIDTH + 1));
  endfunction

  // Every entry is written here, so no later lookup can find an empty one.
  task automatic test_palette_load();
    send_palette(8'd0, 24'h000000);
    send_palette(8'd255, 24'hFFFFFF);
    for (int i = 1; i < PAL_DEPTH - 1; i++)
      send_palette(i[7:0], RGB_W'($urandom_range(24'hFFFFFF)));
  endtask

  task automatic test_directed_cases();
    // Out of reset: 24-bit, one pixel per row, then a single padding byte.
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hFF);
    send_pixel_byte(8'h5A);
    configure(FMT_SPARE, 13'd1);
    send_pixel_byte(8'h12);
    send_pixel_byte(8'h34);
    send_pixel_byte(8'h56);
    send_pixel_byte(8'hA5);
    // With an odd width the second byte's low nibble lies past the row.
    configure(FMT_PAL4, 13'd3);
    send_pixel_byte(8'hF0);
    send_pixel_byte(8'h0F);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hFF);
    // A zero width acts as one; a restart inside the padding begins a new row.
    configure(FMT_PAL8, 13'd0);
    send_pixel_byte(8'hFF);
    send_control(CMD_RESTART);
    send_control(CMD_IGNORED);
    send_pixel_byte(8'h00);
    // Narrowing the row mid-way: the next byte finds the stride passed.
    configure(FMT_PAL8, 13'd6);
    send_palette(8'h80, 24'h123456);
    repeat (4) send_pixel_byte(random_data_byte());
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    send_pixel_byte(8'h80);
    send_pixel_byte(8'h80);
    configure(FMT_BGR24, CFG_W'(WIDTH_TOP));
    send_pixel_byte(8'h01);
    send_pixel_byte(8'h02);
    send_pixel_byte(8'h03);
    send_control(CMD_RESTART);
  endtask

  task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned beats);
    int unsigned start;
    int unsigned stride;
    int unsigned seg;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      configure(2'($urandom_range(3)), random_width());
      // Half the time the row carries on across the register change.
      if ($urandom_range(1) == 0) send_control(CMD_RESTART);
      repeat ($urandom_range(4, 1)) begin
        stride = row_stride_bytes(active_width());
        seg = (stride > 48) ? $urandom_range(48, 8) : stride;
        repeat (seg) begin
          pick = $urandom_range(99);
          if (pick < 4)
            send_palette(8'($urandom_range(255)), RGB_W'($urandom_range(24'hFFFFFF)));
          else if (pick < 6) send_control(CMD_IGNORED);
          else if (pick < 8) send_control(CMD_RESTART);
          else send_pixel_byte(random_data_byte());
        end
        if (seg < stride) send_control(CMD_RESTART);
      end
    end
  endtask

  initial begin
    cur_format = FMT_BGR24;
    cur_width  = 13'd1;
    clear_row_position();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 74;
    test_palette_load();
    test_directed_cases();
    test_random_stream(14, 74, PHASE_BEATS);
    test_random_stream(74, 14, PHASE_BEATS);
    test_random_stream(0, 0, PHASE_BEATS);
    drain_pixels();

    $display("Sent %0d beats and checked %0d pixels in all four format codes,",
             beats_sent, pixels_checked);
    $display("widths from zero to %0d, with sender and receiver idling in turn.", WIDTH_TOP);
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("bmp_pixel_row_decoder_tb passed");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", failures, expected_pixels.size());
      $display("bmp_pixel_row_decoder_tb failed");
    end
    $finish;
  end

endmodule
